// ===== hdl/assert_macros.svh =====
// assertion macros shared by the display writer modules
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SSDW_ASSERT_IMPLY(lbl, a_clk, a_rst_n, ante, cons) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SSDW_ASSERT_NEXT(lbl, a_clk, a_rst_n, ante, cons) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSDW_ASSERT_IMPLY(lbl, a_clk, a_rst_n, ante, cons)
`define SSDW_ASSERT_NEXT(lbl, a_clk, a_rst_n, ante, cons)
`endif
`endif

// ===== hdl/ssdw_pkg.sv =====
// shared types, constants and helper functions of the display writer
// no dependencies
`default_nettype none
package ssdw_pkg;

    // field widths
    localparam int HBT_W       = 16;
    localparam int VALUE_W     = 14;
    localparam int SEGS_W      = 32;
    localparam int BCD_W       = 20;
    localparam int BRIGHT_W    = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // parameter defaults and config reset values
    localparam int                DELAY_WIDTH_DEF  = 16;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RST     = 3'd7;
    localparam logic              DISPLAY_ON_RST   = 1'b1;
    localparam logic [HBT_W-1:0]  HBT_RST          = 16'd100;

    // command queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // bus command bytes
    localparam logic [7:0] BUS_DATA_SET = 8'h40;
    localparam logic [7:0] BUS_ADDR_SET = 8'hC0;
    localparam logic [7:0] COLON_BIT    = 8'h80;

    // opcode on the input channel
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_DECIMAL = 2'd1,
        OP_RAW     = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_NONE  = 2'd2
    } cmd_t;

    // config register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_DISPLAY_ON = 2'd1,
        CFG_HALF_BIT   = 2'd2
    } cfg_reg_t;

    // sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE         = 5'd0,
        PH_START_HI     = 5'd1,
        PH_START_LO     = 5'd2,
        PH_BIT_CLK_LO   = 5'd3,
        PH_BIT_DATA     = 5'd4,
        PH_BIT_CLK_HI   = 5'd5,
        PH_ACK_CLK_LO   = 5'd6,
        PH_ACK_RELEASE  = 5'd7,
        PH_ACK_SAMPLE   = 5'd8,
        PH_ACK_CLK_LO2  = 5'd9,
        PH_STOP_DATA_LO = 5'd10,
        PH_STOP_CLK_HI  = 5'd11,
        PH_STOP_DATA_HI = 5'd12,
        PH_PAUSE        = 5'd13
    } phase_t;

    // queue entry
    typedef struct packed {
        cmd_t              kind;
        logic [SEGS_W-1:0] segs;
        logic              dio;
    } item_t;

    // seven-segment pattern of one decimal digit
    function automatic logic [7:0] seg_of(logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'b00111111;
            4'd1:    pat = 8'b00000110;
            4'd2:    pat = 8'b01011011;
            4'd3:    pat = 8'b01001111;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    // seven shift-add-3 steps of binary to bcd conversion
    function automatic logic [BCD_W-1:0] dabble7(logic [BCD_W-1:0] bcd_in, logic [6:0] bits);
        logic [BCD_W-1:0] b;
        b = bcd_in;
        for (int i = 6; i >= 0; i--)
        begin
            for (int d = 0; d < BCD_W / 4; d++)
            begin
                if (b[4*d +: 4] >= 4'd5)
                begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bits[i]};
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/seven_segment_display_serial_writer_core.sv =====
// Two-wire seven-segment display writer: front end, command queue, bus sequencer.
// Each result passes the front stage, a queue entry and the result register.
// One request per cycle unless results stall; the sequencer steps once per bit delay.
// While a result waits, the 4-entry queue and the front stage take 5 more requests.
// Reset (rst_n, asynchronous, active low): sequencer idle, clock and data lines high,
// brightness 7, display on, 100 ticks per bit delay.
`default_nettype none
module seven_segment_display_serial_writer_core
#(
    parameter int DELAY_WIDTH = ssdw_pkg::DELAY_WIDTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request in
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // number_value[13:0], blank_leading[14], colon_on[15], raw_segments[47:16],
    // dio_sample[48], zero fill[55:49]
    input  wire logic [55:0]                         s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]                          s_tuser,
    // result out
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // clock_level[0], data_level[1], data_drive[2], busy_res[3], ack_level[4],
    // command_dropped[5], zero fill[7:6]
    output logic [7:0]                               m_tdata,
    // config write
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ssdw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ssdw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_not_empty;
    ssdw_pkg::item_t push_item;
    ssdw_pkg::item_t head_item;
    logic [5:0]      result_bits;

    assign cfg_ready = 1'b1;

    ssdw_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .opcode        (ssdw_pkg::op_t'(s_tuser)),
        .number_value  (s_tdata[13:0]),
        .blank_leading (s_tdata[14]),
        .colon_on      (s_tdata[15]),
        .raw_segments  (s_tdata[47:16]),
        .dio_sample    (s_tdata[48]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    ssdw_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    ssdw_back
    #(
        .DELAY_WIDTH (DELAY_WIDTH)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_sel     (ssdw_pkg::cfg_reg_t'(cfg_index)),
        .cfg_value   (cfg_data),
        .q_not_empty (q_not_empty),
        .q_head      (head_item),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_bits    (result_bits)
    );

    assign m_tdata = {2'b00, result_bits};

endmodule
`default_nettype wire

// ===== hdl/ssdw_front.sv =====
// front end: accepts input items, classifies them and encodes decimal numbers
// depends on ssdw_pkg
`default_nettype none
module ssdw_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ssdw_pkg::op_t                  opcode,
    input  wire logic [ssdw_pkg::VALUE_W-1:0]   number_value,
    input  wire logic                           blank_leading,
    input  wire logic                           colon_on,
    input  wire logic [ssdw_pkg::SEGS_W-1:0]    raw_segments,
    input  wire logic                           dio_sample,
    input  wire logic                           q_full,
    output logic                                q_push,
    output ssdw_pkg::item_t                     q_item
);

    logic                          s1_valid_reg;
    ssdw_pkg::op_t                 s1_op_reg;
    logic [ssdw_pkg::VALUE_W-1:0]  s1_value_reg;
    logic                          s1_blank_reg;
    logic                          s1_colon_reg;
    logic [ssdw_pkg::SEGS_W-1:0]   s1_raw_reg;
    logic                          s1_dio_reg;
    logic [ssdw_pkg::BCD_W-1:0]    s1_bcd_reg;
    logic                          s1_load;
    logic [ssdw_pkg::BCD_W-1:0]    bcd_full;
    logic [ssdw_pkg::SEGS_W-1:0]   encoded;
    logic [3:0]                    shown;

    // stage one moves whenever the queue takes its item
    assign q_push   = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || !q_full;
    assign s1_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // first half of the bcd conversion on the upper seven bits
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg    <= opcode;
            s1_value_reg <= number_value;
            s1_blank_reg <= blank_leading;
            s1_colon_reg <= colon_on;
            s1_raw_reg   <= raw_segments;
            s1_dio_reg   <= dio_sample;
            s1_bcd_reg   <= ssdw_pkg::dabble7('0, number_value[13:7]);
        end
    end

    // second half of the conversion and digit encoding
    assign bcd_full = ssdw_pkg::dabble7(s1_bcd_reg, s1_value_reg[6:0]);
    assign shown[3] = (s1_value_reg > 14'd999) || !s1_blank_reg;
    assign shown[2] = (s1_value_reg > 14'd99)  || !s1_blank_reg;
    assign shown[1] = (s1_value_reg > 14'd9)   || !s1_blank_reg;
    assign shown[0] = (s1_value_reg != '0)     || !s1_blank_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            encoded[8*i +: 8] = shown[i]
                ? (ssdw_pkg::seg_of(bcd_full[4*i +: 4])
                   | (s1_colon_reg ? ssdw_pkg::COLON_BIT : 8'h00))
                : 8'h00;
        end
    end

    // classification into the queue entry
    always_comb
    begin
        q_item.dio  = s1_dio_reg;
        q_item.segs = s1_raw_reg;
        case (s1_op_reg)
            ssdw_pkg::OP_TICK:
            begin
                q_item.kind = ssdw_pkg::CMD_TICK;
            end
            ssdw_pkg::OP_DECIMAL:
            begin
                q_item.kind = ssdw_pkg::CMD_WRITE;
                q_item.segs = encoded;
            end
            ssdw_pkg::OP_RAW:
            begin
                q_item.kind = ssdw_pkg::CMD_WRITE;
            end
            default:
            begin
                q_item.kind = ssdw_pkg::CMD_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/ssdw_queue.sv =====
// short command queue between front end and sequencer
// depends on ssdw_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module ssdw_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ssdw_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output ssdw_pkg::item_t      head_item
);

    ssdw_pkg::item_t                  entry_reg [ssdw_pkg::QDEPTH];
    logic [ssdw_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [ssdw_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [ssdw_pkg::QCNT_W-1:0]      count_reg;
    logic [ssdw_pkg::QCNT_W-1:0]      count_next;

    assign full      = (count_reg == ssdw_pkg::QCNT_W'(ssdw_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + ssdw_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - ssdw_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ssdw_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ssdw_pkg::QPTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SSDW_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full)
    `SSDW_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, not_empty)
    `SSDW_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_reg <= ssdw_pkg::QCNT_W'(ssdw_pkg::QDEPTH))

endmodule
`default_nettype wire

// ===== hdl/ssdw_back.sv =====
// back end: bus sequencer, config registers and result register
// depends on ssdw_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module ssdw_back
#(
    parameter int DELAY_WIDTH = ssdw_pkg::DELAY_WIDTH_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire ssdw_pkg::cfg_reg_t                cfg_sel,
    input  wire logic [ssdw_pkg::CFG_DATA_W-1:0]   cfg_value,
    input  wire logic                              q_not_empty,
    input  wire ssdw_pkg::item_t                   q_head,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [5:0]                             out_bits
);

    logic [ssdw_pkg::BRIGHT_W-1:0] bright_reg;
    logic                          on_reg;
    logic [ssdw_pkg::HBT_W-1:0]    hbt_reg;

    ssdw_pkg::phase_t              phase_reg;
    ssdw_pkg::phase_t              phase_next;
    logic [2:0]                    fbi_reg;
    logic [2:0]                    fbi_next;
    logic [2:0]                    bit_reg;
    logic [2:0]                    bit_next;
    logic [DELAY_WIDTH-1:0]        delay_reg;
    logic [DELAY_WIDTH-1:0]        delay_next;
    logic [7:0]                    shift_reg;
    logic [7:0]                    shift_next;
    logic [ssdw_pkg::SEGS_W-1:0]   segs_reg;
    logic [ssdw_pkg::SEGS_W-1:0]   segs_next;
    logic                          ack_reg;
    logic                          ack_next;
    logic                          clk_out_reg;
    logic                          clk_out_next;
    logic                          dat_out_reg;
    logic                          dat_out_next;
    logic                          out_valid_reg;
    logic [5:0]                    out_bits_reg;

    logic                          idle;
    logic                          is_write;
    logic                          write_ok;
    logic                          dropped;
    logic                          tick_busy;
    logic                          act;
    logic                          dec;
    logic [ssdw_pkg::HBT_W-1:0]    hbt_m1;
    logic [DELAY_WIDTH-1:0]        reload;

    // byte of the frame sequence at a given position
    function automatic logic [7:0] byte_at(logic [2:0] idx, logic [31:0] segs,
                                           logic [2:0] bright, logic on);
        logic [7:0] b;
        case (idx)
            3'd0:    b = ssdw_pkg::BUS_DATA_SET;
            3'd1:    b = ssdw_pkg::BUS_ADDR_SET;
            3'd2:    b = segs[31:24];
            3'd3:    b = segs[23:16];
            3'd4:    b = segs[15:8];
            3'd5:    b = segs[7:0];
            3'd6:    b = {on, 3'b000, on, bright};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= ssdw_pkg::BRIGHT_RST;
            on_reg     <= ssdw_pkg::DISPLAY_ON_RST;
            hbt_reg    <= ssdw_pkg::HBT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                ssdw_pkg::CFG_BRIGHTNESS: bright_reg <= cfg_value[ssdw_pkg::BRIGHT_W-1:0];
                ssdw_pkg::CFG_DISPLAY_ON: on_reg     <= cfg_value[0];
                ssdw_pkg::CFG_HALF_BIT:   hbt_reg    <= cfg_value;
                default:                  ;
            endcase
        end
    end

    // bit delay reload, zero treated as one, saturated to the counter range
    assign hbt_m1 = (hbt_reg == '0) ? '0 : hbt_reg - ssdw_pkg::HBT_W'(1);
    generate
        if (DELAY_WIDTH >= ssdw_pkg::HBT_W)
        begin : g_reload_wide
            assign reload = (DELAY_WIDTH)'(hbt_m1);
        end
        else
        begin : g_reload_sat
            assign reload = (|hbt_m1[ssdw_pkg::HBT_W-1:DELAY_WIDTH])
                ? '1 : hbt_m1[DELAY_WIDTH-1:0];
        end
    endgenerate

    // command decode, one queue entry per free result slot
    assign q_pop     = q_not_empty && (!out_valid_reg || out_ready);
    assign idle      = (phase_reg == ssdw_pkg::PH_IDLE);
    assign is_write  = q_pop && (q_head.kind == ssdw_pkg::CMD_WRITE);
    assign write_ok  = is_write && idle;
    assign dropped   = is_write && !idle;
    assign tick_busy = q_pop && (q_head.kind == ssdw_pkg::CMD_TICK) && !idle;
    assign act       = tick_busy && (delay_reg == '0);
    assign dec       = tick_busy && (delay_reg != '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (write_ok)
        begin
            phase_next = ssdw_pkg::PH_START_HI;
        end
        else if (act)
        begin
            case (phase_reg)
                ssdw_pkg::PH_START_HI:     phase_next = ssdw_pkg::PH_START_LO;
                ssdw_pkg::PH_START_LO:     phase_next = ssdw_pkg::PH_BIT_CLK_LO;
                ssdw_pkg::PH_BIT_CLK_LO:   phase_next = ssdw_pkg::PH_BIT_DATA;
                ssdw_pkg::PH_BIT_DATA:     phase_next = ssdw_pkg::PH_BIT_CLK_HI;
                ssdw_pkg::PH_BIT_CLK_HI:
                    phase_next = (bit_reg >= 3'd7) ? ssdw_pkg::PH_ACK_CLK_LO
                                                   : ssdw_pkg::PH_BIT_CLK_LO;
                ssdw_pkg::PH_ACK_CLK_LO:   phase_next = ssdw_pkg::PH_ACK_RELEASE;
                ssdw_pkg::PH_ACK_RELEASE:  phase_next = ssdw_pkg::PH_ACK_SAMPLE;
                ssdw_pkg::PH_ACK_SAMPLE:   phase_next = ssdw_pkg::PH_ACK_CLK_LO2;
                ssdw_pkg::PH_ACK_CLK_LO2:
                    phase_next = (fbi_reg == 3'd0 || fbi_reg >= 3'd5)
                        ? ssdw_pkg::PH_STOP_DATA_LO : ssdw_pkg::PH_BIT_CLK_LO;
                ssdw_pkg::PH_STOP_DATA_LO: phase_next = ssdw_pkg::PH_STOP_CLK_HI;
                ssdw_pkg::PH_STOP_CLK_HI:  phase_next = ssdw_pkg::PH_STOP_DATA_HI;
                ssdw_pkg::PH_STOP_DATA_HI:
                    phase_next = (fbi_reg >= 3'd6) ? ssdw_pkg::PH_PAUSE
                                                   : ssdw_pkg::PH_START_HI;
                ssdw_pkg::PH_PAUSE:
                    phase_next = (bit_reg >= 3'd5) ? ssdw_pkg::PH_IDLE
                                                   : ssdw_pkg::PH_PAUSE;
                default:                   phase_next = ssdw_pkg::PH_IDLE;
            endcase
        end
    end

    // sequencer datapath and pin levels
    always_comb
    begin
        fbi_next     = fbi_reg;
        bit_next     = bit_reg;
        delay_next   = delay_reg;
        shift_next   = shift_reg;
        segs_next    = segs_reg;
        ack_next     = ack_reg;
        clk_out_next = clk_out_reg;
        dat_out_next = dat_out_reg;
        if (write_ok)
        begin
            segs_next  = q_head.segs;
            fbi_next   = '0;
            bit_next   = '0;
            delay_next = '0;
        end
        else if (dec)
        begin
            delay_next = delay_reg - (DELAY_WIDTH)'(1);
        end
        else if (act)
        begin
            delay_next = reload;
            case (phase_reg)
                ssdw_pkg::PH_START_HI:
                begin
                    dat_out_next = 1'b1;
                end
                ssdw_pkg::PH_START_LO:
                begin
                    dat_out_next = 1'b0;
                    shift_next   = byte_at(fbi_reg, segs_reg, bright_reg, on_reg);
                    bit_next     = '0;
                end
                ssdw_pkg::PH_BIT_CLK_LO:
                begin
                    clk_out_next = 1'b0;
                end
                ssdw_pkg::PH_BIT_DATA:
                begin
                    dat_out_next = shift_reg[0];
                end
                ssdw_pkg::PH_BIT_CLK_HI:
                begin
                    clk_out_next = 1'b1;
                    shift_next   = {1'b0, shift_reg[7:1]};
                    bit_next     = (bit_reg >= 3'd7) ? 3'd0 : bit_reg + 3'd1;
                end
                ssdw_pkg::PH_ACK_CLK_LO:
                begin
                    clk_out_next = 1'b0;
                end
                ssdw_pkg::PH_ACK_RELEASE:
                begin
                end
                ssdw_pkg::PH_ACK_SAMPLE:
                begin
                    ack_next     = q_head.dio;
                    dat_out_next = 1'b0;
                end
                ssdw_pkg::PH_ACK_CLK_LO2:
                begin
                    clk_out_next = 1'b0;
                    if (!(fbi_reg == 3'd0 || fbi_reg >= 3'd5))
                    begin
                        fbi_next   = fbi_reg + 3'd1;
                        shift_next = byte_at(fbi_reg + 3'd1, segs_reg, bright_reg, on_reg);
                        bit_next   = '0;
                    end
                end
                ssdw_pkg::PH_STOP_DATA_LO:
                begin
                    dat_out_next = 1'b0;
                end
                ssdw_pkg::PH_STOP_CLK_HI:
                begin
                    clk_out_next = 1'b1;
                end
                ssdw_pkg::PH_STOP_DATA_HI:
                begin
                    dat_out_next = 1'b1;
                    if (fbi_reg >= 3'd6)
                    begin
                        bit_next = '0;
                    end
                    else
                    begin
                        fbi_next = fbi_reg + 3'd1;
                    end
                end
                ssdw_pkg::PH_PAUSE:
                begin
                    if (bit_reg >= 3'd5)
                    begin
                        bit_next   = '0;
                        delay_next = '0;
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
                default:
                begin
                    delay_next = '0;
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ssdw_pkg::PH_IDLE;
            fbi_reg     <= '0;
            bit_reg     <= '0;
            delay_reg   <= '0;
            shift_reg   <= '0;
            segs_reg    <= '0;
            ack_reg     <= 1'b0;
            clk_out_reg <= 1'b1;
            dat_out_reg <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            fbi_reg     <= fbi_next;
            bit_reg     <= bit_next;
            delay_reg   <= delay_next;
            shift_reg   <= shift_next;
            segs_reg    <= segs_next;
            ack_reg     <= ack_next;
            clk_out_reg <= clk_out_next;
            dat_out_reg <= dat_out_next;
        end
    end

    // result register, one result per queue entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_bits_reg <= {dropped,
                             ack_next,
                             phase_next != ssdw_pkg::PH_IDLE,
                             phase_next != ssdw_pkg::PH_ACK_SAMPLE,
                             dat_out_next,
                             clk_out_next};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bits  = out_bits_reg;

    `SSDW_ASSERT_IMPLY(a_idle_delay_clear, clk, rst_n, idle, delay_reg == '0)
    `SSDW_ASSERT_IMPLY(a_pause_count, clk, rst_n,
                       phase_reg == ssdw_pkg::PH_PAUSE, bit_reg <= 3'd5)
    `SSDW_ASSERT_NEXT(a_drop_reported, clk, rst_n, dropped, out_valid && out_bits[5])

endmodule
`default_nettype wire

// ===== tb/ssdw_bus_checker.sv =====
// checker for the seven-segment display writer: watches the request, result and
// config channels, predicts the pin levels of every request and compares them
// depends on ssdw_pkg for the opcode, phase and config register codes
`timescale 1ns / 1ps
module ssdw_bus_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [55:0]                           s_tdata,
    input  logic [1:0]                            s_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [7:0]                            m_tdata,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [ssdw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ssdw_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    mismatches,
    output int                                    outstanding
);
    import ssdw_pkg::*;

    localparam logic [7:0] DISPLAY_ON_BITS = 8'h88;

    // pin levels of one result, clock level in bit 0
    typedef struct packed {
        logic dropped;
        logic ack;
        logic busy;
        logic drive;
        logic data;
        logic clock;
    } pin_levels_t;

    // config copy
    logic [BRIGHT_W-1:0] bright_cfg;
    logic                disp_on_cfg;
    logic [HBT_W-1:0]    half_bit_cfg;

    // sequencer copy
    phase_t              phase;
    logic [2:0]          frame_idx;
    logic [2:0]          bit_cnt;
    logic [15:0]         delay_left;
    logic [7:0]          out_byte;
    logic [31:0]         digit_bytes;
    logic                ack_seen;
    logic                clk_pin;
    logic                dio_pin;

    logic [7:0]          digit_pattern [0:9];
    pin_levels_t         expected_pins [$];
    pin_levels_t         want;

    initial
    begin
        digit_pattern[0] = 8'h3F;
        digit_pattern[1] = 8'h06;
        digit_pattern[2] = 8'h5B;
        digit_pattern[3] = 8'h4F;
        digit_pattern[4] = 8'h66;
        digit_pattern[5] = 8'h6D;
        digit_pattern[6] = 8'h7D;
        digit_pattern[7] = 8'h07;
        digit_pattern[8] = 8'h7F;
        digit_pattern[9] = 8'h6F;
    end

    // reload value of the bit delay, zero counts as one tick
    function automatic logic [15:0] bit_delay();
        logic [15:0] ticks;
        ticks = (half_bit_cfg == '0) ? 16'd1 : half_bit_cfg;
        return ticks - 16'd1;
    endfunction

    // byte sent at a given position of the whole update
    function automatic logic [7:0] frame_byte(logic [2:0] idx);
        logic [31:0] shifted;
        shifted = digit_bytes >> (8 * (5 - int'(idx)));
        case (idx)
            3'd0:                  return BUS_DATA_SET;
            3'd1:                  return BUS_ADDR_SET;
            3'd2, 3'd3, 3'd4, 3'd5: return shifted[7:0];
            3'd6:                  return {5'b0, bright_cfg} | (disp_on_cfg ? DISPLAY_ON_BITS : 8'h00);
            default:               return 8'h00;
        endcase
    endfunction

    // four digit bytes of a decimal value, first digit on top
    function automatic logic [31:0] number_segments(logic [13:0] v, logic blank, logic colon);
        logic [31:0] segs_word;
        int unsigned div;
        segs_word = '0;
        div = 1000;
        for (int i = 0; i < 4; i++)
        begin
            segs_word = segs_word << 8;
            // positions the value does not reach stay dark when blanking
            if (!(blank && v < div))
            begin
                segs_word[7:0] = digit_pattern[(v / div) % 10] | (colon ? COLON_BIT : 8'h00);
            end
            div = div / 10;
        end
        return segs_word;
    endfunction

    // one pin action once the bit delay has run out
    task automatic pin_step(input logic dio);
        phase_t next;
        logic   to_idle;
        next = PH_IDLE;
        to_idle = 1'b0;
        case (phase)
            PH_START_HI:
            begin
                dio_pin = 1'b1;
                next = PH_START_LO;
            end
            PH_START_LO:
            begin
                dio_pin = 1'b0;
                out_byte = frame_byte(frame_idx);
                bit_cnt = '0;
                next = PH_BIT_CLK_LO;
            end
            PH_BIT_CLK_LO:
            begin
                clk_pin = 1'b0;
                next = PH_BIT_DATA;
            end
            PH_BIT_DATA:
            begin
                dio_pin = out_byte[0];
                next = PH_BIT_CLK_HI;
            end
            PH_BIT_CLK_HI:
            begin
                clk_pin = 1'b1;
                out_byte = out_byte >> 1;
                if (bit_cnt >= 3'd7)
                begin
                    bit_cnt = '0;
                    next = PH_ACK_CLK_LO;
                end
                else
                begin
                    bit_cnt = bit_cnt + 3'd1;
                    next = PH_BIT_CLK_LO;
                end
            end
            PH_ACK_CLK_LO:
            begin
                clk_pin = 1'b0;
                next = PH_ACK_RELEASE;
            end
            PH_ACK_RELEASE:
            begin
                next = PH_ACK_SAMPLE;
            end
            PH_ACK_SAMPLE:
            begin
                ack_seen = dio;
                dio_pin = 1'b0;
                next = PH_ACK_CLK_LO2;
            end
            PH_ACK_CLK_LO2:
            begin
                clk_pin = 1'b0;
                // single-byte frames and the last digit byte end in a stop
                if (frame_idx == 3'd0 || frame_idx >= 3'd5)
                begin
                    next = PH_STOP_DATA_LO;
                end
                else
                begin
                    frame_idx = frame_idx + 3'd1;
                    out_byte = frame_byte(frame_idx);
                    bit_cnt = '0;
                    next = PH_BIT_CLK_LO;
                end
            end
            PH_STOP_DATA_LO:
            begin
                dio_pin = 1'b0;
                next = PH_STOP_CLK_HI;
            end
            PH_STOP_CLK_HI:
            begin
                clk_pin = 1'b1;
                next = PH_STOP_DATA_HI;
            end
            PH_STOP_DATA_HI:
            begin
                dio_pin = 1'b1;
                if (frame_idx >= 3'd6)
                begin
                    bit_cnt = '0;
                    next = PH_PAUSE;
                end
                else
                begin
                    frame_idx = frame_idx + 3'd1;
                    next = PH_START_HI;
                end
            end
            PH_PAUSE:
            begin
                // five delays of pause, back to idle on the one after
                if (bit_cnt >= 3'd5)
                begin
                    bit_cnt = '0;
                    to_idle = 1'b1;
                end
                else
                begin
                    bit_cnt = bit_cnt + 3'd1;
                    next = PH_PAUSE;
                end
            end
            default:
            begin
                to_idle = 1'b1;
            end
        endcase
        if (to_idle)
        begin
            phase = PH_IDLE;
            delay_left = '0;
        end
        else
        begin
            phase = next;
            delay_left = bit_delay();
        end
    endtask

    // pin levels after one request
    task automatic predict_levels(input op_t op, input logic [13:0] v, input logic blank,
                                  input logic colon, input logic [31:0] raw, input logic dio);
        pin_levels_t levels;
        levels = '0;
        if (op == OP_DECIMAL || op == OP_RAW)
        begin
            // writes only land while idle
            if (phase != PH_IDLE)
            begin
                levels.dropped = 1'b1;
            end
            else
            begin
                digit_bytes = (op == OP_DECIMAL) ? number_segments(v, blank, colon) : raw;
                phase = PH_START_HI;
                frame_idx = '0;
                bit_cnt = '0;
                delay_left = '0;
            end
        end
        else if (op == OP_TICK && phase != PH_IDLE)
        begin
            if (delay_left != '0)
            begin
                delay_left = delay_left - 16'd1;
            end
            else
            begin
                pin_step(dio);
            end
        end
        levels.clock = clk_pin;
        levels.data  = dio_pin;
        levels.drive = (phase != PH_ACK_SAMPLE);
        levels.busy  = (phase != PH_IDLE);
        levels.ack   = ack_seen;
        expected_pins.push_back(levels);
    endtask

    task automatic check_field(input string field, input logic want_bit, input logic got_bit);
        if (want_bit !== got_bit)
        begin
            $error("%s: expected %0d, got %0d", field, want_bit, got_bit);
            mismatches++;
        end
    endtask

    // follow config writes, requests and results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_cfg   = BRIGHT_RST;
            disp_on_cfg  = DISPLAY_ON_RST;
            half_bit_cfg = HBT_RST;
            phase        = PH_IDLE;
            frame_idx    = '0;
            bit_cnt      = '0;
            delay_left   = '0;
            out_byte     = '0;
            digit_bytes  = '0;
            ack_seen     = 1'b0;
            clk_pin      = 1'b1;
            dio_pin      = 1'b1;
            expected_pins.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_BRIGHTNESS: bright_cfg   = cfg_data[BRIGHT_W-1:0];
                    CFG_DISPLAY_ON: disp_on_cfg  = cfg_data[0];
                    CFG_HALF_BIT:   half_bit_cfg = cfg_data[HBT_W-1:0];
                    default:        ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_levels(op_t'(s_tuser), s_tdata[13:0], s_tdata[14], s_tdata[15],
                               s_tdata[47:16], s_tdata[48]);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pins.size() == 0)
                begin
                    $error("result %h arrived with nothing expected", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    check_field("clock_level", want.clock, m_tdata[0]);
                    check_field("data_level", want.data, m_tdata[1]);
                    check_field("data_drive", want.drive, m_tdata[2]);
                    check_field("busy_res", want.busy, m_tdata[3]);
                    check_field("ack_level", want.ack, m_tdata[4]);
                    check_field("command_dropped", want.dropped, m_tdata[5]);
                end
            end
            outstanding = expected_pins.size();
        end
    end

endmodule

// ===== tb/tb_seven_segment_display_serial_writer_core.sv =====
// top of the display writer testbench: clock, reset, request and config stimulus,
// receiver stalls and verdict; checking lives in ssdw_bus_checker
// depends on ssdw_pkg, ssdw_bus_checker and seven_segment_display_serial_writer_core
`timescale 1ns / 1ps
module tb_seven_segment_display_serial_writer_core;
    import ssdw_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [55:0]            s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int   mismatches;
    int   outstanding;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_go      = 1'b0;
    int   hold_cnt     = 0;
    int   quiet_cycles = 0;

    seven_segment_display_serial_writer_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssdw_bus_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: one long hold-off on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_go && hold_cnt != HOLD_CYCLES)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("tb_seven_segment_display_serial_writer_core: errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // one request, after an optional random gap
    task automatic send_request(input op_t op, input logic [13:0] val, input logic blank,
                                input logic colon, input logic [31:0] raw, input logic dio);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, dio, raw, colon, blank, val};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // mostly ticks stepping the bus, with writes, dropped writes and unused opcodes
    task automatic run_random(input int count);
        int          roll;
        op_t         op;
        logic [13:0] val;
        for (int i = 0; i < count; i++)
        begin
            roll = int'($urandom_range(0, 99));
            if (roll < 91)
                op = OP_TICK;
            else if (roll < 94)
                op = OP_DECIMAL;
            else if (roll < 97)
                op = OP_RAW;
            else
                op = OP_NONE;
            // digit boundaries and values past four digits are favored
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 10))
                    0:       val = 14'd0;
                    1:       val = 14'd1;
                    2:       val = 14'd9;
                    3:       val = 14'd10;
                    4:       val = 14'd99;
                    5:       val = 14'd100;
                    6:       val = 14'd999;
                    7:       val = 14'd1000;
                    8:       val = 14'd9999;
                    9:       val = 14'd10000;
                    default: val = 14'h3FFF;
                endcase
            end
            else
            begin
                val = 14'($urandom_range(0, 16383));
            end
            send_request(op, val, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    // all three registers in one burst of config writes
    task automatic write_config(input logic [BRIGHT_W-1:0] bright, input logic on,
                                input logic [HBT_W-1:0] half_bit);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BRIGHTNESS;
        cfg_data  <= {{(CFG_DATA_W-BRIGHT_W){1'b0}}, bright};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_DISPLAY_ON;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, on};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_HALF_BIT;
        cfg_data  <= half_bit;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, tick and unused opcode while idle, a write,
        // dropped writes and unused opcode while busy
        send_request(OP_TICK, 14'd0, 1'b0, 1'b0, 32'd0, 1'b0);
        send_request(OP_NONE, 14'h3FFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_DECIMAL, 14'd0, 1'b1, 1'b1, 32'd0, 1'b0);
        send_request(OP_DECIMAL, 14'd9999, 1'b0, 1'b0, 32'd0, 1'b1);
        send_request(OP_RAW, 14'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_NONE, 14'd0, 1'b0, 1'b0, 32'd0, 1'b0);
        for (int i = 0; i < 12; i++)
            send_request(OP_TICK, 14'h3FFF, 1'b1, 1'b1, 32'hFFFF_FFFF, i[0]);

        // no idling, lowest brightness, display off; one long receiver hold-off
        drain();
        write_config(3'd0, 1'b0, 16'd1);
        hold_go <= 1'b1;
        send_request(OP_DECIMAL, 14'd0, 1'b1, 1'b0, $urandom, 1'b0);
        run_random(450);

        // sender mostly idle
        drain();
        write_config(3'd7, 1'b1, 16'd1);
        tx_idle_pct = 81;
        send_request(OP_DECIMAL, 14'h3FFF, 1'b0, 1'b1, $urandom, 1'b1);
        run_random(350);

        // receiver mostly stalled, zero delay setting
        drain();
        write_config(3'd5, 1'b1, 16'd0);
        tx_idle_pct  = 0;
        rx_stall_pct = 81;
        send_request(OP_RAW, 14'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        run_random(400);

        // light idling on both sides, two ticks per delay
        drain();
        write_config(3'd2, 1'b0, 16'd2);
        tx_idle_pct  = 9;
        rx_stall_pct = 9;
        send_request(OP_DECIMAL, 14'd7, 1'b1, 1'b1, $urandom, 1'b0);
        run_random(400);

        // longest delay setting
        drain();
        write_config(3'd1, 1'b1, 16'hFFFF);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(30);

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_seven_segment_display_serial_writer_core: clean");
        else
            $display("tb_seven_segment_display_serial_writer_core: errors");
        $finish;
    end

endmodule
